// File: design/matrix3x3_inverse_unit_defines.svh
// assertion macros for the matrix inverse unit design file
`ifndef MATRIX3X3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3X3_INVERSE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define M3I_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define M3I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/m3i_pkg.sv
// shared widths, types and helper functions of the 3x3 matrix inverse
package m3i_pkg;

  localparam int DataW     = 32;
  localparam int ThrW      = 63;
  localparam int AdjW      = 64;
  localparam int DetW      = 97;
  localparam int DmW       = 96;
  localparam int QW        = DataW;
  localparam int Lanes     = 9;
  localparam int DivStages = QW;

  // operand indexes of the two cofactor products: adj = a[i]*a[j] - a[k]*a[l]
  localparam int AdjIdx [Lanes][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  localparam logic [QW-1:0] SatPos = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] SatNeg = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic [DmW-1:0] rem;
    logic [QW-1:0]  q;
    logic           neg;
    logic           over;
  } m3i_lane_t;

  typedef struct packed {
    logic [DmW-1:0]          dmag;
    logic                    sing;
    m3i_lane_t [Lanes-1:0]   lane;
  } m3i_div_t;

  // sign, saturation and singular forcing of one finished quotient
  function automatic logic [QW-1:0] m3i_finish(m3i_lane_t l, logic sing);
    logic [QW-1:0] res;
    if (sing) begin
      res = '0;
    end else if (l.neg) begin
      if (l.over || (l.q[QW-1] && (l.q[QW-2:0] != '0))) res = SatNeg;
      else res = QW'(-l.q);
    end else begin
      if (l.over || l.q[QW-1]) res = SatPos;
      else res = l.q;
    end
    return res;
  endfunction

endpackage

// File: design/m3i_div_stage.sv
// one restoring division step for all nine lanes, registered
module m3i_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  m3i_pkg::m3i_div_t  in_data,
  output logic               out_valid,
  output m3i_pkg::m3i_div_t  out_data
);
  import m3i_pkg::*;

  logic     valid_r, valid_nxt;
  m3i_div_t data_r, data_nxt;

  always_comb begin
    logic [DmW:0]   rem2;
    logic [DmW+1:0] diff;
    data_nxt = in_data;
    for (int k = 0; k < Lanes; k++) begin
      rem2 = {in_data.lane[k].rem, 1'b0};
      diff = {1'b0, rem2} - {2'b00, in_data.dmag};
      if (!diff[DmW+1]) begin
        data_nxt.lane[k].rem = diff[DmW-1:0];
      end else begin
        data_nxt.lane[k].rem = rem2[DmW-1:0];
      end
      data_nxt.lane[k].q = {in_data.lane[k].q[QW-2:0], ~diff[DmW+1]};
    end
    valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: design/matrix3x3_inverse_unit.sv
// 3x3 fixed-point matrix inverse by adjugate and determinant, fully pipelined
// One row-major Q16.16 matrix enters per cycle while in_stall is low, and its
// Q16.16 inverse leaves after the front stages (cofactor products, determinant
// and compare), a restoring divider that yields one quotient bit per stage for
// all nine entries at once, and sign and saturation into the output register.
// A two-entry output (register plus skid) lets the pipeline keep moving while
// a finished item waits, and in_stall rises only when both are full.
// A matrix whose determinant is zero or whose magnitude is below the
// cfg_wr_data threshold (Q32.32, compared against the Q48.48 determinant) gives
// out_invertible low and all nine entries zero. Otherwise each entry is
// truncated toward zero and saturated to the signed 32-bit range.
// Write cfg_wr_data with cfg_wr_en only while no item is in flight.
`include "matrix3x3_inverse_unit_defines.svh"

module matrix3x3_inverse_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [m3i_pkg::ThrW-1:0]             cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r0c0,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r0c1,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r0c2,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r1c0,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r1c1,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r1c2,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r2c0,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r2c1,
  input  logic signed [m3i_pkg::DataW-1:0]     in_m_r2c2,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r0c0,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r0c1,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r0c2,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r1c0,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r1c1,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r1c2,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r2c0,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r2c1,
  output logic signed [m3i_pkg::DataW-1:0]     out_inv_r2c2,
  output logic                                 out_invertible
);
  import m3i_pkg::*;

  localparam int FrontN = 7;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [AdjW-1:0]  adj_t;

  // pipeline global advance: frozen only while the skid entry is occupied
  logic en;

  // configuration
  logic [ThrW-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrW'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // front stage valids
  logic [FrontN-1:0] vld_r, vld_nxt;

  // stage 1: cofactor products
  word_t a [Lanes];
  adj_t  p0_r [Lanes], p1_r [Lanes];
  word_t c1_r [3];
  // stage 2: adjugate
  adj_t  adj2_r [Lanes];
  word_t c2_r [3];
  // stage 3: determinant partial products
  adj_t                    ph_r [3];
  logic signed [AdjW:0]    pl_r [3];
  adj_t                    adj3_r [Lanes];
  // stage 4: determinant terms
  logic signed [DetW-1:0]  t_r [3];
  adj_t                    adj4_r [Lanes];
  // stage 5: determinant
  logic signed [DetW-1:0]  det_r;
  adj_t                    adj5_r [Lanes];
  // stage 6: magnitudes
  logic [DmW-1:0]          dmag_r;
  logic                    dneg_r;
  logic [AdjW-1:0]         am_r [Lanes];
  logic [Lanes-1:0]        an_r;
  // stage 7: divider entry
  m3i_div_t                div_in_r, div_in_nxt;

  assign a[0] = in_m_r0c0;
  assign a[1] = in_m_r0c1;
  assign a[2] = in_m_r0c2;
  assign a[3] = in_m_r1c0;
  assign a[4] = in_m_r1c1;
  assign a[5] = in_m_r1c2;
  assign a[6] = in_m_r2c0;
  assign a[7] = in_m_r2c1;
  assign a[8] = in_m_r2c2;

  assign vld_nxt = {vld_r[FrontN-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // divider entry: singular test, overflow test, quotient sign
  always_comb begin
    logic [DmW-1:0] thr_ext;
    thr_ext = {{(DmW-ThrW-16){1'b0}}, thr_r, 16'd0};
    div_in_nxt.dmag = dmag_r;
    div_in_nxt.sing = (dmag_r == '0) || (dmag_r < thr_ext);
    for (int k = 0; k < Lanes; k++) begin
      div_in_nxt.lane[k].rem  = {{(DmW-AdjW){1'b0}}, am_r[k]};
      div_in_nxt.lane[k].q    = '0;
      div_in_nxt.lane[k].neg  = an_r[k] ^ dneg_r;
      // integer part of adj/det nonzero means the Q16.16 result overflows
      div_in_nxt.lane[k].over = ({{(DmW-AdjW){1'b0}}, am_r[k]} >= dmag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int k = 0; k < Lanes; k++) begin
        p0_r[k] <= a[AdjIdx[k][0]] * a[AdjIdx[k][1]];
        p1_r[k] <= a[AdjIdx[k][2]] * a[AdjIdx[k][3]];
      end
      for (int j = 0; j < 3; j++) begin
        c1_r[j] <= a[j];
      end
      // stage 2
      for (int k = 0; k < Lanes; k++) begin
        adj2_r[k] <= p0_r[k] - p1_r[k];
      end
      c2_r <= c1_r;
      // stage 3: first row against adjugate column 0, split into 32-bit halves
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= c2_r[j] * $signed(adj2_r[3*j][AdjW-1:DataW]);
        pl_r[j] <= c2_r[j] * $signed({1'b0, adj2_r[3*j][DataW-1:0]});
      end
      adj3_r <= adj2_r;
      // stage 4
      for (int j = 0; j < 3; j++) begin
        t_r[j] <= $signed({ph_r[j][AdjW-1], ph_r[j], {DataW{1'b0}}})
                + $signed({{(DetW-AdjW-1){pl_r[j][AdjW]}}, pl_r[j]});
      end
      adj4_r <= adj3_r;
      // stage 5
      det_r  <= t_r[0] + t_r[1] + t_r[2];
      adj5_r <= adj4_r;
      // stage 6
      dneg_r <= det_r[DetW-1];
      dmag_r <= det_r[DetW-1] ? DmW'(-det_r) : det_r[DmW-1:0];
      for (int k = 0; k < Lanes; k++) begin
        an_r[k] <= adj5_r[k][AdjW-1];
        am_r[k] <= adj5_r[k][AdjW-1] ? AdjW'(-adj5_r[k]) : AdjW'(adj5_r[k]);
      end
      // stage 7
      div_in_r <= div_in_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  logic     div_v [DivStages+1];
  m3i_div_t div_d [DivStages+1];

  assign div_v[0] = vld_r[FrontN-1];
  assign div_d[0] = div_in_r;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    m3i_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (div_v[s]),
      .in_data   (div_d[s]),
      .out_valid (div_v[s+1]),
      .out_data  (div_d[s+1])
    );
  end

  // finishing: sign, saturation, singular forcing
  logic [QW-1:0] fin [Lanes];
  logic          fin_inv;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      fin[k] = m3i_finish(div_d[DivStages].lane[k], div_d[DivStages].sing);
    end
    fin_inv = ~div_d[DivStages].sing;
  end

  // output register plus skid entry
  logic          out_v_r, out_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  logic [QW-1:0] out_q_r [Lanes];
  logic          out_inv_r;
  logic [QW-1:0] skid_q_r [Lanes];
  logic          skid_inv_r;
  logic          out_free, arrive, load_out, load_skid;

  assign en       = ~skid_v_r;
  assign in_stall = skid_v_r;
  assign out_free = ~out_v_r | ~out_stall;
  assign arrive   = en & div_v[DivStages];

  always_comb begin
    load_out   = 1'b0;
    load_skid  = 1'b0;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = arrive;
        load_out  = arrive;
      end
    end else if (arrive) begin
      skid_v_nxt = 1'b1;
      load_skid  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && skid_v_r) begin
      out_q_r   <= skid_q_r;
      out_inv_r <= skid_inv_r;
    end else if (load_out) begin
      out_q_r   <= fin;
      out_inv_r <= fin_inv;
    end
    if (load_skid) begin
      skid_q_r   <= fin;
      skid_inv_r <= fin_inv;
    end
  end

  assign out_valid      = out_v_r;
  assign out_invertible = out_inv_r;
  assign out_inv_r0c0   = out_q_r[0];
  assign out_inv_r0c1   = out_q_r[1];
  assign out_inv_r0c2   = out_q_r[2];
  assign out_inv_r1c0   = out_q_r[3];
  assign out_inv_r1c1   = out_q_r[4];
  assign out_inv_r1c2   = out_q_r[5];
  assign out_inv_r2c0   = out_q_r[6];
  assign out_inv_r2c1   = out_q_r[7];
  assign out_inv_r2c2   = out_q_r[8];

  // singular items carry an all-zero matrix
  `M3I_ASSERT_SAME(a_sing_zero, out_valid && !out_invertible,
    out_inv_r0c0 == 0 && out_inv_r0c1 == 0 && out_inv_r0c2 == 0 &&
    out_inv_r1c0 == 0 && out_inv_r1c1 == 0 && out_inv_r1c2 == 0 &&
    out_inv_r2c0 == 0 && out_inv_r2c1 == 0 && out_inv_r2c2 == 0,
    "singular item with nonzero entries")

  // input back-pressure only when a finished item is waiting
  `M3I_ASSERT_SAME(a_stall_out, in_stall, out_valid, "input stalled with empty output")

  // a held output keeps the skid entry occupied
  `M3I_ASSERT_NEXT(a_skid_hold, out_valid && out_stall && in_stall, in_stall,
    "skid entry lost while output held")

  // divider-output remainder stays below the divisor unless singular or overflowing
  for (genvar k = 0; k < Lanes; k++) begin : g_chk
    `M3I_ASSERT_SAME(a_rem_bound,
      div_v[DivStages] && !div_d[DivStages].sing && !div_d[DivStages].lane[k].over,
      div_d[DivStages].lane[k].rem < div_d[DivStages].dmag,
      "divider remainder out of range")
  end

endmodule

// File: tb/tb.sv
// testbench for the 3x3 fixed-point matrix inverse unit
module tb;
  import m3i_pkg::*;

  // one row-major matrix, and the inverse with its flag
  typedef logic signed [DataW-1:0] mat_t [Lanes];
  typedef struct {
    logic signed [DataW-1:0] e [Lanes];
    logic                    ok;
  } inv_t;

  localparam int        DrainCycles = 60;      // pipeline is about 40 deep
  localparam int        CycleLimit  = 400000;
  localparam logic [DataW-1:0] One  = 32'h0001_0000;
  localparam logic [ThrW-1:0]  ThrMax = {ThrW{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [ThrW-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DataW-1:0] in_m [Lanes];
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [DataW-1:0] out_inv [Lanes];
  logic out_invertible;

  // testbench copy of the threshold register
  logic [ThrW-1:0] thr_now = 63'd1;
  inv_t inverse_q [$];
  int errors = 0;
  int matrices_sent = 0;
  int inverses_seen = 0;
  int singular_seen = 0;
  int cycles = 0;
  bit idle_en = 1'b1;   // random gaps and stalls on or off
  int long_hold = 0;    // receiver hold-off, counted down in the receiver

  initial for (int k = 0; k < Lanes; k++) in_m[k] = '0;

  always #1 clk = ~clk;

  matrix3x3_inverse_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m_r0c0(in_m[0]), .in_m_r0c1(in_m[1]), .in_m_r0c2(in_m[2]),
    .in_m_r1c0(in_m[3]), .in_m_r1c1(in_m[4]), .in_m_r1c2(in_m[5]),
    .in_m_r2c0(in_m[6]), .in_m_r2c1(in_m[7]), .in_m_r2c2(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inv_r0c0(out_inv[0]), .out_inv_r0c1(out_inv[1]), .out_inv_r0c2(out_inv[2]),
    .out_inv_r1c0(out_inv[3]), .out_inv_r1c1(out_inv[4]), .out_inv_r1c2(out_inv[5]),
    .out_inv_r2c0(out_inv[6]), .out_inv_r2c1(out_inv[7]), .out_inv_r2c2(out_inv[8]),
    .out_invertible(out_invertible)
  );

  // adjugate over determinant, exact in wide arithmetic, then truncate and saturate
  function automatic inv_t predict_inverse(mat_t a, logic [ThrW-1:0] thr);
    logic signed [63:0]  cof [Lanes];
    logic signed [127:0] det;
    logic [127:0] dmag, lim, num, q;
    logic [63:0]  am;
    logic         dneg, neg;
    inv_t r;
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[2] * a[7] - a[1] * a[8];
    cof[2] = a[1] * a[5] - a[2] * a[4];
    cof[3] = a[5] * a[6] - a[3] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[2] * a[3] - a[0] * a[5];
    cof[6] = a[3] * a[7] - a[4] * a[6];
    cof[7] = a[1] * a[6] - a[0] * a[7];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    dneg = det[127];
    dmag = dneg ? -det : det;
    // threshold is Q32.32, determinant Q48.48
    lim = 128'(thr) << 16;
    r.ok = !(dmag == '0 || dmag < lim);
    for (int k = 0; k < Lanes; k++) begin
      r.e[k] = '0;
      if (r.ok) begin
        am  = cof[k][63] ? -cof[k] : cof[k];
        num = 128'(am) << 32;
        q   = num / dmag;
        neg = cof[k][63] ^ dneg;
        if (neg) r.e[k] = (q > 128'h8000_0000) ? SatNeg : 32'(-q);
        else r.e[k] = (q > 128'h7fff_ffff) ? SatPos : q[31:0];
      end
    end
    return r;
  endfunction

  // offer one matrix after a random gap; valid stays high across back-to-back items
  task automatic send_matrix(mat_t m);
    int gap;
    gap = idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < Lanes; k++) in_m[k] <= m[k];
    do @(posedge clk); while (in_stall);
    inverse_q.push_back(predict_inverse(m, thr_now));
    matrices_sent++;
  endtask

  // sender pauses until every inverse is back, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_now = v;
  endtask

  function automatic mat_t diag(logic signed [DataW-1:0] d0, logic signed [DataW-1:0] d1,
                                logic signed [DataW-1:0] d2);
    mat_t m;
    for (int k = 0; k < Lanes; k++) m[k] = '0;
    m[0] = d0; m[4] = d1; m[8] = d2;
    return m;
  endfunction

  function automatic mat_t fill(logic signed [DataW-1:0] v);
    mat_t m;
    for (int k = 0; k < Lanes; k++) m[k] = v;
    return m;
  endfunction

  // mixes well-conditioned, near-singular, singular and full-range matrices
  function automatic mat_t random_matrix();
    mat_t m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < Lanes; k++) begin
      case (kind)
        0, 1, 2: m[k] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        3, 4:    m[k] = $urandom();
        5:       m[k] = $signed($urandom_range(0, 64)) - 32;
        6:       m[k] = $urandom_range(0, 1) ? SatNeg : SatPos;
        default: m[k] = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      endcase
    end
    // dependent rows make exact singular cases, a tiny nudge makes near-singular ones
    if (kind == 7) begin
      for (int k = 0; k < 3; k++) m[6 + k] = m[k];
    end else if (kind == 8) begin
      for (int k = 0; k < 3; k++) m[3 + k] = m[k];
      m[4] = m[4] + $signed($urandom_range(0, 4)) - 2;
    end
    return m;
  endfunction

  task automatic test_directed();
    mat_t m;
    send_matrix(diag(One, One, One));                          // identity
    send_matrix(diag(-One, -One, -One));
    send_matrix(fill('0));                                     // zero determinant
    send_matrix(fill(SatPos));
    send_matrix(fill(SatNeg));
    send_matrix(diag(SatNeg, SatNeg, SatNeg));
    send_matrix(diag(SatPos, SatNeg, SatPos));
    send_matrix(diag(32'sd1, 32'sd1, 32'sd1));                 // tiny det, below reset threshold
    send_matrix(diag(32'sd256, 32'sd256, 32'sd256));           // large inverse, fits without saturation
    send_matrix(diag(-32'sd256, 32'sd256, 32'sd256));          // negative large entry, no saturation
    send_matrix(diag(2 * One, 4 * One, -8 * One));
    m = diag(One, One, One);
    m[1] = SatPos; m[5] = SatNeg;                              // unit triangular, big adjugate
    send_matrix(m);
    m = fill(One); m[4] = 2 * One; m[8] = 3 * One;
    send_matrix(m);
    m = diag(One, One, One); m[3] = One;                       // duplicated rows
    m[4] = '0; m[0] = One;
    m[3] = One; m[4] = '0; m[5] = '0;
    send_matrix(m);
    m = diag(32'sd16, 32'sd16, 32'sd16);                       // det below the reset threshold
    send_matrix(m);
    m = diag(32'sd15, 32'sd16, 32'sd16);                       // smaller det, also below it
    send_matrix(m);
    // tiny matrices again with the threshold switched off
    write_threshold('0);
    send_matrix(diag(32'sd1, 32'sd1, 32'sd1));
    send_matrix(diag(32'sd15, 32'sd16, -32'sd16));
    send_matrix(fill('0));                                     // zero det stays singular
    write_threshold(ThrMax);                                   // only very large determinants pass
    send_matrix(diag(SatNeg, SatNeg, SatNeg));
    send_matrix(diag(One, One, One));
    write_threshold(63'h1_0000_0000);                          // det below 1.0 is singular
    send_matrix(diag(One, One, One));
    send_matrix(diag(One, One, One - 1));
    send_matrix(diag(One / 2, 2 * One, 2 * One));
  endtask

  // random matrices under a handful of thresholds, extremes among them
  task automatic test_random(int count);
    logic [ThrW-1:0] thr_set [6];
    thr_set = '{63'd1, 63'd0, 63'h1_0000_0000, 63'h0000_0100_0000_0000, ThrMax,
                ThrW'({$urandom(), $urandom()} >> 1)};
    for (int p = 0; p < 6; p++) begin
      write_threshold(thr_set[p]);
      // saturating threshold gets only a short phase
      for (int n = 0; n < ((p == 4) ? count / 20 : count / 5); n++) begin
        idle_en = ($urandom_range(0, 3) != 0);   // stretches with no idling
        send_matrix(random_matrix());
      end
    end
    idle_en = 1'b1;
  endtask

  // receiver holds off while the sender keeps going until the block stalls its input
  task automatic test_backpressure();
    write_threshold(63'd1);
    long_hold = 300;
    idle_en = 1'b0;
    for (int n = 0; n < 70; n++) send_matrix(random_matrix());
    idle_en = 1'b1;
    drain();
  endtask

  // receiver: random stall per result, checks each accepted inverse in order
  initial begin
    int hold;
    inv_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (inverse_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected inverse, flag %b", $time, out_invertible);
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < Lanes; k++) begin
            if (out_inv[k] !== want.e[k]) begin
              errors++;
              $display("%0t: entry %0d expected %h actual %h", $time, k, want.e[k], out_inv[k]);
            end
          end
          if (out_invertible !== want.ok) begin
            errors++;
            $display("%0t: flag expected %b actual %b", $time, want.ok, out_invertible);
          end
          if (want.ok) inverses_seen++;
          else singular_seen++;
        end
        hold = idle_en ? $urandom_range(0, 12) : 0;
      end
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(620);
    drain();
    $display("covered %0d matrices: %0d inverted, %0d singular, thresholds 0 to max",
             matrices_sent, inverses_seen, singular_seen);
    $display("random gaps and stalls, a long output hold-off and drained config changes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
